### rtl/madr_pkg.sv
// ============================================================================
// Moving-average deviation rate package
// Shared widths, payload types, status codes, controller states and the
// command and status bundles between controller and datapath.
// ============================================================================
package madr_pkg;

    localparam int SAMPLE_W = 31;
    localparam int TAG_W    = 16;
    localparam int RATE_W   = 24;
    localparam int STATUS_W = 2;
    localparam int WLEN_W   = 7;
    localparam int FRAC_W   = 16;
    localparam int QUOT_W   = 24;
    localparam int PROD_W   = SAMPLE_W + WLEN_W;
    localparam int LOW_W    = QUOT_W - FRAC_W;

    typedef logic [SAMPLE_W-1:0]      t_sample;
    typedef logic [TAG_W-1:0]         t_tag;
    typedef logic signed [RATE_W-1:0] t_rate;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [WLEN_W-1:0]        t_wlen;
    typedef logic [QUOT_W-1:0]        t_quot;

    localparam t_wlen   WLEN_RESET = 7'd7;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_SAT  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    localparam t_rate   RATE_MAX = 24'sh7FFFFF;
    // One in Q7.16, and the smallest quotient whose rate no longer fits.
    localparam t_quot   ONE_Q    = 24'h010000;
    localparam t_quot   QUOT_SAT = 24'h810000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_DIV,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic fill;
        logic load;
        logic check;
        logic div_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic filling;
        logic skip;
        logic div_last;
        logic out_busy;
    } t_stat;

endpackage

### rtl/madr_if.sv
// ============================================================================
// Moving-average deviation rate channels
// Valid/ready channels for input samples, results and the window register.
// ============================================================================
interface madr_in_if import madr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    t_tag    tag;

    modport source (output valid, sample, tag, input ready);
    modport sink   (input valid, sample, tag, output ready);
endinterface

interface madr_out_if import madr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_rate   rate;
    t_status status;
    t_tag    tag_out;

    modport source (output valid, rate, status, tag_out, input ready);
    modport sink   (input valid, rate, status, tag_out, output ready);
endinterface

interface madr_cfg_if import madr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_wlen window_len;

    modport source (output valid, window_len, input ready);
    modport sink   (input valid, window_len, output ready);
endinterface

### rtl/madr_ctrl.sv
// ============================================================================
// Moving-average deviation rate controller
// Sequences items one at a time: load; if full, check, divide if needed, update.
// ============================================================================
module madr_ctrl import madr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = i_stat.filling ? S_IDLE : S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.skip ? S_UPDATE : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.fill = i_stat.filling;
                o_cmd.load = !i_stat.filling;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = !i_stat.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/madr_dp.sv
// ============================================================================
// Moving-average deviation rate datapath
// Delay-line memory, running sum, multiplier, bit-serial divider and the
// output register.
// ============================================================================
module madr_dp import madr_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  t_sample i_sample,
    input  t_tag    i_tag,
    input  logic    i_cfg_valid,
    input  t_wlen   i_cfg_window_len,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_rate   o_rate,
    output t_status o_status,
    output t_tag    o_tag_out
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int LMAX  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
    localparam int SUM_W = SAMPLE_W + $clog2(LMAX);

    t_sample               mem [WINDOW_MAX];

    t_wlen                 r_window_len;
    logic [AW-1:0]         r_write_slot;
    t_wlen                 r_seen_count;
    logic [SUM_W-1:0]      r_sum;

    t_sample               r_sample;
    t_tag                  r_tag;
    logic [AW-1:0]         r_slot;
    logic [PROD_W-1:0]     r_prod;
    t_sample               r_hist;
    logic [SUM_W:0]        r_rem;
    t_quot                 r_quot;
    logic [4:0]            r_cnt;
    logic                  r_zero;
    logic                  r_ovf;

    logic                  r_out_valid;
    t_rate                 r_rate;
    t_status               r_status;
    t_tag                  r_tag_out;

    t_wlen                 w_len;
    logic [AW-1:0]         w_slot;
    logic [AW-1:0]         w_next_slot;
    logic [SUM_W-1:0]      w_prod_hi;
    logic [QUOT_W-1:0]     w_low;
    logic [SUM_W:0]        w_shift;
    logic [SUM_W:0]        w_diff;
    logic                  w_zero;
    logic                  w_ovf;
    t_rate                 n_rate;
    t_status               n_status;

    // Effective window: zero acts as one, values above the memory depth clamp.
    always_comb begin
        if (r_window_len == '0) begin
            w_len = WLEN_W'(1);
        end else if (int'(r_window_len) > WINDOW_MAX) begin
            w_len = WLEN_W'(WINDOW_MAX);
        end else begin
            w_len = r_window_len;
        end
    end

    assign w_slot      = (int'(r_write_slot) >= int'(w_len)) ? '0 : r_write_slot;
    assign w_next_slot = (int'(r_slot) + 1 == int'(w_len)) ? '0 : r_slot + AW'(1);

    assign w_prod_hi = SUM_W'(r_prod[PROD_W-1:LOW_W]);
    assign w_low     = {r_prod[LOW_W-1:0], FRAC_W'(0)};
    assign w_zero    = (r_sum == '0);
    assign w_ovf     = (w_prod_hi >= r_sum);
    assign w_shift   = {r_rem[SUM_W-1:0], w_low[r_cnt]};
    assign w_diff    = w_shift - {1'b0, r_sum};

    assign o_stat.filling  = (r_seen_count < w_len);
    assign o_stat.skip     = w_zero || w_ovf;
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        if (r_zero) begin
            n_rate   = '0;
            n_status = ST_ZERO;
        end else if (r_ovf || r_quot >= QUOT_SAT) begin
            n_rate   = RATE_MAX;
            n_status = ST_SAT;
        end else begin
            n_rate   = t_rate'(r_quot - ONE_Q);
            n_status = ST_OK;
        end
    end

    // Window state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
            r_write_slot <= '0;
            r_seen_count <= '0;
            r_sum        <= '0;
        end else if (i_cfg_valid) begin
            r_window_len <= i_cfg_window_len;
            r_write_slot <= '0;
            r_seen_count <= '0;
            r_sum        <= '0;
        end else if (i_cmd.fill) begin
            r_write_slot <= w_next_slot;
            r_seen_count <= r_seen_count + WLEN_W'(1);
            r_sum        <= r_sum + SUM_W'(r_sample);
        end else if (i_cmd.update) begin
            r_write_slot <= w_next_slot;
            r_sum        <= r_sum - SUM_W'(r_hist) + SUM_W'(r_sample);
        end
    end

    // Delay line.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill || i_cmd.update) begin
            mem[r_slot] <= r_sample;
        end
        if (i_cmd.load) begin
            r_hist <= mem[r_slot];
        end
    end

    // Item capture, multiply and restoring division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_tag    <= i_tag;
            r_slot   <= w_slot;
        end
        if (i_cmd.load) begin
            r_prod <= PROD_W'(r_sample) * PROD_W'(w_len);
        end
        if (i_cmd.check) begin
            r_zero <= w_zero;
            r_ovf  <= w_ovf;
            r_rem  <= {1'b0, w_prod_hi};
            r_quot <= '0;
            r_cnt  <= 5'(QUOT_W - 1);
        end
        if (i_cmd.div_step) begin
            if (!w_diff[SUM_W]) begin
                r_rem  <= w_diff;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rate    <= n_rate;
            r_status  <= n_status;
            r_tag_out <= r_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rate      = r_rate;
    assign o_status    = r_status;
    assign o_tag_out   = r_tag_out;

endmodule

### rtl/moving_average_deviation_rate_unit.sv
// ============================================================================
// Moving-average deviation rate unit
// Deviation of each sample from the average of the samples before it.
// ============================================================================
// Each input transfer carries a non-negative sample and a tag. The unit keeps
// the last L samples in a delay-line memory and their running sum, where L is
// the window_len register clamped to 1..WINDOW_MAX (zero acts as one). The
// first L transfers after reset or after a window_len write only fill the
// window and give no result. Every later transfer gives one result with
// rate = floor(sample * L * 2^16 / sum) - 2^16 in signed Q7.16, the average
// being that of the L samples before the current one. A rate above the Q7.16
// range reads as the largest value with status 1; a zero prior sum gives
// rate 0 with status 2. Items are handled one at a time: a filling item passes
// through load and back to idle before the next transfer can be taken, and a
// result item through load, check, 24 quotient bits from the restoring divider
// at one bit per cycle, and update. When the prior sum is zero, or the
// quotient cannot fit in 24 bits, the divider is skipped and the item passes
// through load, check and update, then idle. Either kind of result item is held
// in update only while a previous result still waits in the output register.
// A finished result sits in that register while the next input is taken.
// Writing window_len restarts the fill; write it only while the unit is idle.
// The window register channel is always ready.
module moving_average_deviation_rate_unit import madr_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    madr_in_if.sink      i_in,
    madr_out_if.source   o_out,
    madr_cfg_if.sink     i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // The window register is written directly from the channel, so it never stalls.
    assign i_cfg.ready = 1'b1;

    madr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    madr_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_sample         (i_in.sample),
        .i_tag            (i_in.tag),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_window_len (i_cfg.window_len),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_rate           (o_out.rate),
        .o_status         (o_out.status),
        .o_tag_out        (o_out.tag_out)
    );

endmodule

### rtl/madr_checker.sv
// ============================================================================
// Moving-average deviation rate checker
// Port-level assertions on item sequencing and the result register.
// ============================================================================
module madr_checker import madr_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_rate   i_rate,
    input t_status i_status,
    input t_tag    i_tag_out
);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && i_in_ready;

    // One item at a time: in the cycle after a transfer the unit is not ready.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in_ready)
        else $error("input taken in the cycle after a transfer");

    // A new result only appears while an item is in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared with no item in work");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rate) && $stable(i_status) && $stable(i_tag_out)))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind moving_average_deviation_rate_unit madr_checker u_madr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rate      (o_out.rate),
    .i_status    (o_out.status),
    .i_tag_out   (o_out.tag_out)
);

### sim/tb_moving_average_deviation_rate_unit.sv
// ============================================================================
// Moving-average deviation rate unit testbench
// Drives samples through the unit under random idling and back-pressure and
// checks every result against a cycle-free model of the sliding window.
// ============================================================================
// Each accepted sample transfer is run through a behavioral model of the
// window (delay line, running sum, fill count). Items past the fill give one
// expected deviation rate, which is queued and compared field by field with
// the next result transfer. Window length writes happen only when the unit
// is idle, and they restart both the unit and the model from an empty window.
module tb_moving_average_deviation_rate_unit;
    import madr_pkg::*;

    localparam int      WINDOW_MAX    = 64;
    // Longest time the unit can still be busy with an item that gives no
    // result, plus margin for a result that sits in the output register.
    localparam int      SETTLE_CYCLES = 40;
    localparam int      REPORT_LIMIT  = 100;
    localparam t_sample SAMPLE_FULL   = '1;

    typedef struct {
        t_sample sample;
        t_tag    tag;
    } t_item;

    typedef struct {
        t_rate   rate;
        t_status status;
        t_tag    tag;
    } t_deviation;

    logic clk = 1'b0;
    logic rst_n;

    madr_in_if  in_ch ();
    madr_out_if out_ch ();
    madr_cfg_if cfg_ch ();

    moving_average_deviation_rate_unit #(
        .WINDOW_MAX (WINDOW_MAX)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Samples waiting to be offered, and deviation rates the unit still owes.
    t_item      pending_items [$];
    t_deviation expected_rates [$];

    // Model of the window: register, delay line, next slot, fill count, sum.
    t_wlen       mdl_window_len;
    t_sample     mdl_history [WINDOW_MAX];
    int unsigned mdl_slot;
    int unsigned mdl_count;
    logic [36:0] mdl_sum;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned in_idle_pct;
    int unsigned out_stall_pct;

    int unsigned mismatches      = 0;
    int unsigned items_taken     = 0;
    int unsigned results_checked = 0;
    int unsigned sat_seen        = 0;
    int unsigned zero_seen       = 0;
    int unsigned window_writes   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A window length of zero acts as one; anything above the delay line
    // depth is clamped to it.
    function automatic int unsigned effective_window(t_wlen w);
        if (w == 0) return 1;
        if (w > WINDOW_MAX) return WINDOW_MAX;
        return w;
    endfunction

    function automatic void restart_window(t_wlen w);
        mdl_window_len = w;
        mdl_slot       = 0;
        mdl_count      = 0;
        mdl_sum        = '0;
    endfunction

    // Advances the window model by one sample. Once the window is full, the
    // rate is taken against the sum of the samples before this one, and only
    // then does the sample replace the oldest entry.
    function automatic void predict_deviation(t_item it);
        int unsigned len;
        int unsigned slot;
        logic [63:0] num;
        logic [63:0] quot;
        t_deviation  dev;
        len  = effective_window(mdl_window_len);
        slot = (mdl_slot >= len) ? 0 : mdl_slot;
        if (mdl_count < len) begin
            mdl_sum += it.sample;
            mdl_count++;
        end else begin
            dev.tag    = it.tag;
            dev.rate   = '0;
            dev.status = ST_OK;
            if (mdl_sum == 0) begin
                dev.status = ST_ZERO;
                zero_seen++;
            end else begin
                num  = (64'(it.sample) * len) << FRAC_W;
                quot = num / 64'(mdl_sum);
                // The floor of the quotient is at least zero, so only the
                // upper end of the Q7.16 range can be exceeded.
                if (quot > 64'(ONE_Q) + 64'(RATE_MAX)) begin
                    dev.rate   = RATE_MAX;
                    dev.status = ST_SAT;
                    sat_seen++;
                end else begin
                    dev.rate = t_rate'(quot - 64'(ONE_Q));
                end
            end
            expected_rates = {expected_rates, dev};
            mdl_sum = mdl_sum - mdl_history[slot] + it.sample;
        end
        mdl_history[slot] = it.sample;
        mdl_slot          = (slot + 1) % len;
    endfunction

    function automatic void push_item(t_sample s, t_tag t);
        t_item it;
        it.sample = s;
        it.tag    = t;
        pending_items = {pending_items, it};
    endfunction

    // Mostly samples that wander around a per-phase level, so rates land in
    // the ordinary range, mixed with zeros, spikes that saturate, tiny values
    // and fully random words.
    function automatic t_sample next_sample(int unsigned level, int unsigned zero_pct);
        int unsigned pick;
        longint      v;
        if ($urandom_range(99) < zero_pct) return '0;
        pick = $urandom_range(99);
        if (pick < 3) return SAMPLE_FULL;
        if (pick < 13) return t_sample'($urandom);
        if (pick < 20) return t_sample'($urandom_range(0, 15));
        if (pick < 25) begin
            v = longint'(level) * 200;
            if (v > longint'(SAMPLE_FULL)) return SAMPLE_FULL;
            return t_sample'(v);
        end
        v = longint'(level) + longint'($urandom_range(0, level / 2)) - longint'(level / 4);
        return t_sample'(v);
    endfunction

    // Holds the sender back until every queued sample has been taken and
    // every owed result has arrived, then lets the unit finish any fill item.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_rates.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(t_wlen w);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.window_len <= w;
        do @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        restart_window(w);
        window_writes++;
    endtask

    // Sample driver: once a transfer completes, or while nothing is offered,
    // it either presents the next pending sample or leaves valid low. The
    // valid signal is held steady while the unit is not ready.
    always @(posedge clk) begin : sample_driver
        t_item cur;
        t_item nxt;
        logic  took;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            took = in_ch.valid && in_ch.ready;
            if (took) begin
                cur.sample = in_ch.sample;
                cur.tag    = in_ch.tag;
                predict_deviation(cur);
                items_taken++;
            end
            if (!in_ch.valid || took) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.sample <= nxt.sample;
                    in_ch.tag    <= nxt.tag;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every result transfer is matched against the oldest
    // owed deviation rate. Ready is redrawn each cycle to create stalls.
    always @(posedge clk) begin : result_monitor
        t_deviation want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_rates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result: expected none,", $time,
                                 " actual rate %0d status %0d tag %0d",
                                 out_ch.rate, out_ch.status, out_ch.tag_out);
                end else begin
                    want = expected_rates.pop_front();
                    results_checked++;
                    if (out_ch.rate !== want.rate || out_ch.status !== want.status ||
                        out_ch.tag_out !== want.tag) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: result mismatch:", $time,
                                     " expected rate %0d status %0d tag %0d,",
                                     want.rate, want.status, want.tag,
                                     " actual rate %0d status %0d tag %0d",
                                     out_ch.rate, out_ch.status, out_ch.tag_out);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    initial begin : stimulus
        t_wlen       windows [12];
        t_wlen       wlen;
        int unsigned level;
        int unsigned zero_pct;
        int unsigned count;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.tag         = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.window_len = '0;
        restart_window(WLEN_RESET);
        in_idle_pct   = 8;
        out_stall_pct = 45;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset window of seven: an all-zero fill, so the first rate sees a
        // zero prior sum. Then a full-scale sample against a tiny average
        // saturates, and a zero sample gives the lowest rate of all.
        for (int i = 0; i < 7; i++)
            push_item('0, t_tag'(i));
        push_item(t_sample'(5), 16'hFFFF);
        push_item(SAMPLE_FULL, 16'h0000);
        push_item('0, 16'h5555);
        push_item(t_sample'(1), 16'hAAAA);

        // Shortest window: equal neighbors give zero, then a fraction that
        // rounds down, then a zero window sum again.
        wait_idle();
        write_window(7'd1);
        push_item(t_sample'(3), 16'h0101);
        push_item(t_sample'(3), 16'h0102);
        push_item(t_sample'(2), 16'h0103);
        push_item('0, 16'h0104);
        push_item(t_sample'(7), 16'h0105);

        // A window length of zero behaves as one.
        wait_idle();
        write_window(7'd0);
        push_item(SAMPLE_FULL, 16'h0201);
        push_item(t_sample'(1), 16'h0202);
        push_item(t_sample'(200), 16'h0203);
        push_item(t_sample'(100), 16'h0204);

        // Random phases, each after a fresh window length. Every second phase
        // of four is zero-heavy so short windows hit a zero prior sum often.
        windows = '{7'd64, 7'd3, 7'd127, 7'd2, 7'd0, 7'd16,
                    7'd65, 7'd1, 7'd0, 7'd5, 7'd0, 7'd64};
        windows[8]  = t_wlen'($urandom_range(0, 127));
        windows[10] = t_wlen'($urandom_range(0, 127));
        foreach (windows[p]) begin
            if (p == 4) begin
                in_idle_pct   = 45;
                out_stall_pct = 8;
            end
            if (p == 8) begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            wlen     = windows[p];
            level    = $urandom_range(1, 1 << $urandom_range(0, 30));
            zero_pct = (p % 4 == 1) ? 50 : 4;
            count    = effective_window(wlen) + 38;
            wait_idle();
            write_window(wlen);
            for (int i = 0; i < count; i++) begin
                // Once, the sender stops halfway through a phase until the
                // unit has delivered everything it owes.
                if (p == 6 && i == count / 2)
                    wait_idle();
                push_item(next_sample(level, zero_pct), t_tag'($urandom));
            end
        end

        wait_idle();
        $display("Run covered %0d samples over %0d window writes and %0d checked rates,",
                 items_taken, window_writes, results_checked);
        $display("of which %0d saturated and %0d saw a zero prior sum.", sat_seen, zero_seen);
        if (mismatches == 0 && expected_rates.size() == 0) begin
            $display("tb_moving_average_deviation_rate_unit: PASS");
        end else begin
            $display("tb_moving_average_deviation_rate_unit: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("tb_moving_average_deviation_rate_unit: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/madr_pkg.sv
rtl/madr_if.sv
rtl/madr_ctrl.sv
rtl/madr_dp.sv
rtl/moving_average_deviation_rate_unit.sv
rtl/madr_checker.sv
sim/tb_moving_average_deviation_rate_unit.sv
